FILE: design/csdp_pkg.sv
// ============================================================================
// csdp_pkg
// Shared constants for the clock synthesizer divider planner: limits, reset
// values, register indexes and the bit layout of the stream items.
// ============================================================================
package csdp_pkg;

    localparam int NUM_CHANNELS_DEF = 2;

    localparam logic [29:0] VCO_MAX_HZ    = 30'd900000000;
    localparam logic [29:0] DIV_MAX       = 30'd900;
    localparam logic [6:0]  DIV4_BITS     = 7'h0C;
    localparam logic [17:0] P1_OFFSET     = 18'd512;
    localparam logic [25:0] CRYSTAL_RESET = 26'd24998694;
    localparam logic [15:0] OFFSET_RESET  = 16'd608;

    // configuration register indexes
    localparam int          CFG_IDX_W   = 1;
    localparam int          CFG_DATA_W  = 26;
    localparam logic [0:0]  REG_CRYSTAL = 1'd0;
    localparam logic [0:0]  REG_OFFSET  = 1'd1;

    // stream widths
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 88;
    localparam int M_USER_W = 3;

    // input tuser bits
    localparam int SU_CHANNEL = 0;
    localparam int SU_CW      = 1;
    localparam int SU_LSB     = 2;

    // output tuser bits
    localparam int MU_CHANNEL = 0;
    localparam int MU_CHANGED = 1;
    localparam int MU_ERROR   = 2;

    // output tdata field positions (low bit)
    localparam int MD_FB_P1  = 0;
    localparam int MD_FB_P2  = 18;
    localparam int MD_FB_P3  = 38;
    localparam int MD_OUT_P1 = 58;
    localparam int MD_RDIV   = 76;

endpackage

FILE: design/clock_synth_divider_planner.sv
// ============================================================================
// clock_synth_divider_planner
// Plans PLL feedback and output multisynth words for one frequency request.
// ============================================================================
// One request is processed at a time. Three 30-step restoring divisions
// (output divider, feedback integer part, feedback fraction) share one
// bit-per-cycle divider, with R normalization and a bit-serial multiply
// between the first and the second. Rejected requests (offset underflow,
// zero frequency, small crystal) go straight to the finish state. The next
// request is taken while the previous result waits on the output register.
module clock_synth_divider_planner #(
    parameter int NUM_CHANNELS = csdp_pkg::NUM_CHANNELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // freq_hz[27:0], zero fill
    input  logic [csdp_pkg::S_DATA_W-1:0]   s_tdata,
    // channel[0], cw_mode[1], add_offset[2]
    input  logic [csdp_pkg::S_USER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // feedback_p1[17:0], feedback_p2[37:18], feedback_p3[57:38],
    // output_p1[75:58], rdiv_control[82:76], zero fill
    output logic [csdp_pkg::M_DATA_W-1:0]   m_tdata,
    // out_channel[0], output_stage_changed[1], range_error[2]
    output logic [csdp_pkg::M_USER_W-1:0]   m_tuser,
    input  logic                            cfg_we,
    input  logic [csdp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csdp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import csdp_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV    = 3'd1;
    localparam logic [2:0] S_NORM   = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    localparam logic [1:0] P_FREQ = 2'd0;
    localparam logic [1:0] P_VCO  = 2'd1;
    localparam logic [1:0] P_FRAC = 2'd2;

    localparam logic [4:0] DIV_LAST = 5'd29;
    localparam logic [4:0] MUL_LAST = 5'd9;

    logic [25:0] xtal_reg;
    logic [15:0] offset_reg;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        err_reg, err_next;
    logic        ch_reg, ch_next;
    logic [30:0] f_reg, f_next;
    logic [29:0] num_reg, num_next;
    logic [30:0] rem_reg, rem_next;
    logic [30:0] den_reg, den_next;
    logic [2:0]  k_reg, k_next;
    logic [9:0]  div_reg, div_next;
    logic [9:0]  mul_sh_reg, mul_sh_next;
    logic [29:0] acc_reg, acc_next;
    logic [10:0] a_reg, a_next;
    logic [7:0]  fr_reg, fr_next;
    logic [19:0] p2_reg, p2_next;

    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [M_USER_W-1:0] m_tuser_reg;

    logic [15:0] cache_div_reg [NUM_CHANNELS];
    logic [6:0]  cache_r_reg   [NUM_CHANNELS];

    // input front end
    logic [27:0] fin;
    logic [28:0] f_sum, f_diff, f_adj;
    logic        underflow, in_err;
    logic [30:0] f_eff;

    // shared serial divider
    logic [31:0] rem_sh, rem_sub;
    logic        q_bit;
    logic [30:0] rem_step;
    logic [29:0] num_step;

    // serial multiply
    logic [29:0] acc_step;

    // result assembly
    logic        out_free, finish_fire;
    logic [6:0]  rcode;
    logic [6:0]  rdiv;
    logic [17:0] fb_p1, out_p1;
    logic        changed;
    logic [M_DATA_W-1:0] res_data;

    assign out_free    = !m_tvalid_reg || m_tready;
    assign finish_fire = (state_reg == S_FINISH) && out_free;

    always_comb
    begin
        fin       = s_tdata[27:0];
        f_sum     = {1'b0, fin} + {13'd0, offset_reg};
        f_diff    = {1'b0, fin} - {13'd0, offset_reg};
        underflow = (fin < {12'd0, offset_reg});
        f_adj     = {1'b0, fin};
        if (s_tuser[SU_CW])
        begin
            f_adj = s_tuser[SU_LSB] ? f_sum : f_diff;
        end
        if (s_tuser[SU_CHANNEL] == 1'b0)
        begin
            f_eff = {f_adj, 2'b00};
        end
        else
        begin
            f_eff = {3'd0, fin};
        end
        in_err = ((s_tuser[SU_CHANNEL] == 1'b0) && s_tuser[SU_CW] && !s_tuser[SU_LSB]
                  && underflow)
                 || (f_eff == 31'd0) || (xtal_reg < 26'd32);
    end

    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[29]};
        rem_sub  = rem_sh - {1'b0, den_reg};
        q_bit    = (rem_sh >= {1'b0, den_reg});
        rem_step = q_bit ? rem_sub[30:0] : rem_sh[30:0];
        num_step = {num_reg[28:0], q_bit};
        acc_step = {acc_reg[28:0], 1'b0} + (mul_sh_reg[9] ? f_reg[29:0] : 30'd0);
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        err_next    = err_reg;
        ch_next     = ch_reg;
        f_next      = f_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        k_next      = k_reg;
        div_next    = div_reg;
        mul_sh_next = mul_sh_reg;
        acc_next    = acc_reg;
        a_next      = a_reg;
        fr_next     = fr_reg;
        p2_next     = p2_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ch_next    = s_tuser[SU_CHANNEL];
                    err_next   = in_err;
                    f_next     = f_eff;
                    num_next   = VCO_MAX_HZ;
                    rem_next   = '0;
                    den_next   = f_eff;
                    cnt_next   = '0;
                    k_next     = '0;
                    phase_next = P_FREQ;
                    state_next = in_err ? S_FINISH : S_DIV;
                end
            end
            S_DIV:
            begin
                num_next = num_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next = '0;
                    case (phase_reg)
                        P_FREQ:
                        begin
                            state_next = S_NORM;
                        end
                        P_VCO:
                        begin
                            a_next     = num_step[10:0];
                            num_next   = {2'd0, rem_step[25:5], 7'd0};
                            rem_next   = '0;
                            den_next   = {10'd0, xtal_reg[25:5]};
                            phase_next = P_FRAC;
                        end
                        default:
                        begin
                            fr_next    = num_step[7:0];
                            p2_next    = rem_step[19:0];
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_NORM:
            begin
                if (num_reg > DIV_MAX)
                begin
                    if (k_reg == 3'd7)
                    begin
                        err_next   = 1'b1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        num_next = num_reg >> 1;
                        k_next   = k_reg + 3'd1;
                    end
                end
                else if (num_reg[9:1] < 9'd2)
                begin
                    err_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    div_next    = {num_reg[9:1], 1'b0};
                    mul_sh_next = {num_reg[9:1], 1'b0};
                    acc_next    = '0;
                    cnt_next    = '0;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                acc_next    = acc_step;
                mul_sh_next = {mul_sh_reg[8:0], 1'b0};
                cnt_next    = cnt_reg + 5'd1;
                if (cnt_reg == MUL_LAST)
                begin
                    num_next   = acc_step << k_reg;
                    rem_next   = '0;
                    den_next   = {5'd0, xtal_reg};
                    cnt_next   = '0;
                    phase_next = P_VCO;
                    state_next = S_DIV;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rcode    = {k_reg, 4'd0};
        rdiv     = rcode | ((div_reg == 10'd4) ? DIV4_BITS : 7'd0);
        fb_p1    = {a_reg, 7'd0} + {10'd0, fr_reg} - P1_OFFSET;
        out_p1   = {1'b0, div_reg, 7'd0} - P1_OFFSET;
        changed  = 1'b1;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (int'(ch_reg) == i)
            begin
                changed = (cache_div_reg[i] != {6'd0, div_reg}) || (cache_r_reg[i] != rcode);
            end
        end
        res_data = '0;
        res_data[MD_FB_P1 +: 18]  = fb_p1;
        res_data[MD_FB_P2 +: 20]  = p2_reg;
        res_data[MD_FB_P3 +: 20]  = xtal_reg[24:5];
        res_data[MD_OUT_P1 +: 18] = out_p1;
        res_data[MD_RDIV +: 7]    = rdiv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xtal_reg     <= CRYSTAL_RESET;
            offset_reg   <= OFFSET_RESET;
            state_reg    <= S_IDLE;
            phase_reg    <= P_FREQ;
            cnt_reg      <= '0;
            err_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                cache_div_reg[i] <= '0;
                cache_r_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_CRYSTAL)
                begin
                    xtal_reg <= cfg_wdata;
                end
                else if (cfg_index == REG_OFFSET)
                begin
                    offset_reg <= cfg_wdata[15:0];
                end
            end
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
            if (finish_fire)
            begin
                m_tvalid_reg <= 1'b1;
                if (!err_reg)
                begin
                    for (int i = 0; i < NUM_CHANNELS; i++)
                    begin
                        if (int'(ch_reg) == i && changed)
                        begin
                            cache_div_reg[i] <= {6'd0, div_reg};
                            cache_r_reg[i]   <= rcode;
                        end
                    end
                end
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        ch_reg     <= ch_next;
        f_reg      <= f_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        k_reg      <= k_next;
        div_reg    <= div_next;
        mul_sh_reg <= mul_sh_next;
        acc_reg    <= acc_next;
        a_reg      <= a_next;
        fr_reg     <= fr_next;
        p2_reg     <= p2_next;
        if (finish_fire)
        begin
            m_tuser_reg[MU_CHANNEL] <= ch_reg;
            m_tuser_reg[MU_ERROR]   <= err_reg;
            m_tuser_reg[MU_CHANGED] <= !err_reg && changed;
            m_tdata_reg             <= err_reg ? '0 : res_data;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: design/csdp_checker.sv
// ============================================================================
// csdp_checker
// Port-level checks for the divider planner, bound to the top level.
// ============================================================================
module csdp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [csdp_pkg::M_DATA_W-1:0]   m_tdata,
    input logic [csdp_pkg::M_USER_W-1:0]   m_tuser
);
    import csdp_pkg::*;

    // a held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    // one request in flight: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // rejected requests carry no plan and never flag a rewrite
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[MU_ERROR] |-> (m_tdata == '0) && !m_tuser[MU_CHANGED])
        else $error("error item carries data");

    // divide-by-4 bits appear exactly when the output divider is 4
    a_div4: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[MU_ERROR] |->
        ((m_tdata[MD_RDIV+3:MD_RDIV+2] == 2'b11) == (m_tdata[MD_OUT_P1+17:MD_OUT_P1] == 18'd0)))
        else $error("divide-by-4 bits inconsistent with output P1");

endmodule

bind clock_synth_divider_planner csdp_checker u_csdp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

FILE: tb/tb_clock_synth_divider_planner.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_clock_synth_divider_planner
// Self-checking bench for the divider planner. A short table of directed
// requests and register writes goes first: error cases, divide-by-4,
// maximum R, cache hits and offset and crystal extremes. Random requests
// follow under several crystal and offset settings. Each result is compared
// field by field with a plan computed in the bench. Both stream sides stall
// at random, except in one phase that runs without gaps.
// ============================================================================
module tb_clock_synth_divider_planner;
    import csdp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned R_LIMIT     = 128;
    localparam int unsigned IDLE_PCT    = 33;
    localparam int unsigned TAIL_CYCLES = 200;

    typedef struct packed {
        logic        ch;
        logic [17:0] fb_p1;
        logic [19:0] fb_p2;
        logic [19:0] fb_p3;
        logic [17:0] ms_p1;
        logic [6:0]  rdiv;
        logic        changed;
        logic        range_err;
    } plan_t;

    typedef enum logic [1:0] {ROW_ITEM, ROW_CRYSTAL, ROW_OFFSET} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [27:0] value;
        logic [2:0]  user;
        bit          typed_error;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [S_USER_W-1:0]   s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // bench copy of the block state
    logic [25:0] xtal;
    logic [15:0] rx_offset;
    logic [15:0] cache_div   [NUM_CHANNELS_DEF];
    logic [6:0]  cache_rcode [NUM_CHANNELS_DEF];

    plan_t       expected_plans [$];
    row_t        directed_rows [$];
    logic [27:0] last_freq [2];
    bit          steady;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;

    clock_synth_divider_planner #(
        .NUM_CHANNELS(NUM_CHANNELS_DEF)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("clock_synth_divider_planner regression: fail");
            $finish;
        end
    end

    function automatic plan_t plan_request(logic [27:0] freq, logic ch, logic cw, logic lsb);
        logic [63:0] f, dv, r, vco, a, b, c, fr, tmp;
        logic [6:0]  rc, rcode;
        logic        bad;
        plan_t       p;
        p = '0;
        p.ch = ch;
        f = 64'(freq);
        bad = 1'b0;
        dv = '0;
        r = 64'd1;
        rc = '0;
        if (ch == 1'b0)
        begin
            if (cw)
            begin
                if (lsb)
                    f = f + 64'(rx_offset);
                else if (f < 64'(rx_offset))
                    bad = 1'b1;
                else
                    f = f - 64'(rx_offset);
            end
            f = f << 2;
        end
        if (!bad && (f == 64'd0 || xtal < 26'd32))
            bad = 1'b1;
        if (!bad)
        begin
            dv = 64'(VCO_MAX_HZ) / f;
            while (dv > 64'(DIV_MAX))
            begin
                r = r << 1;
                dv = dv >> 1;
            end
            dv[0] = 1'b0;
            if (r > 64'(R_LIMIT) || dv < 64'd4)
                bad = 1'b1;
        end
        if (bad)
        begin
            p.range_err = 1'b1;
            return p;
        end
        while ((64'd1 << rc) < r)
            rc++;
        rcode = {rc[2:0], 4'b0000};
        vco = dv * r * f;
        a = vco / 64'(xtal);
        b = (vco % 64'(xtal)) >> 5;
        c = 64'(xtal) >> 5;
        fr = (64'd128 * b) / c;
        tmp = 64'd128 * a + fr - 64'(P1_OFFSET);
        p.fb_p1 = tmp[17:0];
        tmp = 64'd128 * b - fr * c;
        p.fb_p2 = tmp[19:0];
        p.fb_p3 = c[19:0];
        tmp = 64'd128 * dv - 64'(P1_OFFSET);
        p.ms_p1 = tmp[17:0];
        p.rdiv = rcode | ((dv == 64'd4) ? DIV4_BITS : 7'd0);
        if (int'(ch) < NUM_CHANNELS_DEF)
        begin
            p.changed = (cache_div[ch] != dv[15:0]) || (cache_rcode[ch] != rcode);
            if (p.changed)
            begin
                cache_div[ch] = dv[15:0];
                cache_rcode[ch] = rcode;
            end
        end
        else
        begin
            p.changed = 1'b1;
        end
        return p;
    endfunction

    function automatic logic [2:0] mk_user(logic ch, logic cw, logic lsb);
        logic [2:0] u;
        u = '0;
        u[SU_CHANNEL] = ch;
        u[SU_CW] = cw;
        u[SU_LSB] = lsb;
        return u;
    endfunction

    function automatic logic [27:0] pick_freq(logic [27:0] last);
        int unsigned sel, width;
        sel = $urandom_range(99);
        if (sel < 20)
            return last;
        if (sel < 40)
            return last + 28'($urandom_range(4000)) - 28'd2000;
        if (sel < 85)
        begin
            width = $urandom_range(27, 12);
            return 28'($urandom_range((1 << width) - 1, 1 << (width - 1)));
        end
        if (sel < 95)
            return 28'($urandom);
        return 28'($urandom_range(8000));
    endfunction

    task automatic add_row(row_kind_t kind, logic [27:0] value, logic [2:0] user, bit typed_error);
        row_t row;
        row.kind = kind;
        row.value = value;
        row.user = user;
        row.typed_error = typed_error;
        directed_rows.push_back(row);
    endtask

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic send_request(logic [27:0] freq, logic [2:0] user, bit typed_error);
        plan_t want;
        if (!steady)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_DATA_W'(freq);
        s_tuser <= user;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = plan_request(freq, user[SU_CHANNEL], user[SU_CW], user[SU_LSB]);
        if (typed_error)
        begin
            want = '0;
            want.ch = user[SU_CHANNEL];
            want.range_err = 1'b1;
        end
        expected_plans.push_back(want);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_plans.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_CRYSTAL)
            xtal = val[25:0];
        else
            rx_offset = val[15:0];
        @(posedge clk);
    endtask

    task automatic run_phase(logic [25:0] crystal, logic [15:0] offset, int count, bit no_gaps);
        logic [2:0]  user;
        logic [27:0] freq;
        wait_for_results();
        write_reg(REG_CRYSTAL, CFG_DATA_W'(crystal));
        write_reg(REG_OFFSET, CFG_DATA_W'(offset));
        steady = no_gaps;
        repeat (count)
        begin
            user = 3'($urandom_range(7));
            freq = pick_freq(last_freq[user[SU_CHANNEL]]);
            last_freq[user[SU_CHANNEL]] = freq;
            send_request(freq, user, 1'b0);
        end
        steady = 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin : result_check
        plan_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.ch        = m_tuser[MU_CHANNEL];
            got.changed   = m_tuser[MU_CHANGED];
            got.range_err = m_tuser[MU_ERROR];
            got.fb_p1     = m_tdata[MD_FB_P1 +: 18];
            got.fb_p2     = m_tdata[MD_FB_P2 +: 20];
            got.fb_p3     = m_tdata[MD_FB_P3 +: 20];
            got.ms_p1     = m_tdata[MD_OUT_P1 +: 18];
            got.rdiv      = m_tdata[MD_RDIV +: 7];
            if (expected_plans.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, got tdata 0x%0h tuser 0x%0h",
                         $time, m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                want = expected_plans.pop_front();
                check_field("out_channel", 64'(want.ch), 64'(got.ch));
                check_field("feedback_p1", 64'(want.fb_p1), 64'(got.fb_p1));
                check_field("feedback_p2", 64'(want.fb_p2), 64'(got.fb_p2));
                check_field("feedback_p3", 64'(want.fb_p3), 64'(got.fb_p3));
                check_field("output_p1", 64'(want.ms_p1), 64'(got.ms_p1));
                check_field("rdiv_control", 64'(want.rdiv), 64'(got.rdiv));
                check_field("output_stage_changed", 64'(want.changed), 64'(got.changed));
                check_field("range_error", 64'(want.range_err), 64'(got.range_err));
            end
        end
    end

    always @(posedge clk)
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

    initial
    begin
        rst_n = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        steady = 1'b0;
        xtal = CRYSTAL_RESET;
        rx_offset = OFFSET_RESET;
        for (int i = 0; i < NUM_CHANNELS_DEF; i++)
        begin
            cache_div[i] = '0;
            cache_rcode[i] = '0;
        end
        last_freq[0] = 28'd7030000;
        last_freq[1] = 28'd7030000;

        // errors: zero frequency, offset underflow, R over 128, divider below 4
        add_row(ROW_ITEM, 28'd0, mk_user(1'b1, 1'b0, 1'b0), 1'b1);
        add_row(ROW_ITEM, 28'd0, mk_user(1'b0, 1'b0, 1'b0), 1'b1);
        add_row(ROW_ITEM, 28'd100, mk_user(1'b0, 1'b1, 1'b0), 1'b1);
        add_row(ROW_ITEM, 28'd608, mk_user(1'b0, 1'b1, 1'b0), 1'b1);
        add_row(ROW_ITEM, 28'd100, mk_user(1'b0, 1'b1, 1'b1), 1'b1);
        add_row(ROW_ITEM, 28'd4000, mk_user(1'b1, 1'b0, 1'b0), 1'b1);
        add_row(ROW_ITEM, 28'hFFFFFFF, mk_user(1'b1, 1'b0, 1'b0), 1'b1);
        add_row(ROW_ITEM, 28'd225000001, mk_user(1'b1, 1'b0, 1'b0), 1'b1);
        // divide-by-4, max R, cache hits, both sidebands, offset extremes
        add_row(ROW_ITEM, 28'd225000000, mk_user(1'b1, 1'b0, 1'b0), 1'b0);
        add_row(ROW_ITEM, 28'd200000000, mk_user(1'b1, 1'b0, 1'b0), 1'b0);
        add_row(ROW_ITEM, 28'd56250000, mk_user(1'b0, 1'b0, 1'b0), 1'b0);
        add_row(ROW_ITEM, 28'd10000, mk_user(1'b1, 1'b0, 1'b0), 1'b0);
        add_row(ROW_ITEM, 28'd7050000, mk_user(1'b1, 1'b0, 1'b0), 1'b0);
        add_row(ROW_ITEM, 28'd7050000, mk_user(1'b1, 1'b1, 1'b1), 1'b0);
        add_row(ROW_ITEM, 28'd7030000, mk_user(1'b0, 1'b1, 1'b1), 1'b0);
        add_row(ROW_ITEM, 28'd7030000, mk_user(1'b0, 1'b1, 1'b0), 1'b0);
        add_row(ROW_OFFSET, 28'd65535, '0, 1'b0);
        add_row(ROW_ITEM, 28'd65535, mk_user(1'b0, 1'b1, 1'b0), 1'b1);
        add_row(ROW_ITEM, 28'hFFFFFFF, mk_user(1'b0, 1'b1, 1'b1), 1'b1);
        add_row(ROW_OFFSET, 28'd0, '0, 1'b0);
        add_row(ROW_ITEM, 28'd14060000, mk_user(1'b0, 1'b1, 1'b0), 1'b0);
        // crystal too small for c, then the largest crystal
        add_row(ROW_CRYSTAL, 28'd31, '0, 1'b0);
        add_row(ROW_ITEM, 28'd7050000, mk_user(1'b1, 1'b0, 1'b0), 1'b1);
        add_row(ROW_CRYSTAL, 28'h3FFFFFF, '0, 1'b0);
        add_row(ROW_ITEM, 28'd144000000, mk_user(1'b1, 1'b0, 1'b0), 1'b0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_ITEM)
            begin
                send_request(directed_rows[i].value, directed_rows[i].user,
                             directed_rows[i].typed_error);
            end
            else
            begin
                wait_for_results();
                write_reg((directed_rows[i].kind == ROW_CRYSTAL) ? REG_CRYSTAL : REG_OFFSET,
                          CFG_DATA_W'(directed_rows[i].value));
            end
        end

        run_phase(CRYSTAL_RESET, OFFSET_RESET, 300, 1'b0);
        run_phase(26'd10000000, 16'd0, 200, 1'b0);
        run_phase(26'd40000000, 16'd65535, 200, 1'b1);
        run_phase(26'h3FFFFFF, 16'($urandom), 150, 1'b0);
        run_phase(26'd31, OFFSET_RESET, 20, 1'b0);
        run_phase(26'd32, 16'd1, 60, 1'b0);
        run_phase(26'($urandom_range(40000000, 10000000)), 16'($urandom), 200, 1'b0);
        run_phase(26'd0, 16'd12345, 10, 1'b0);
        run_phase(CRYSTAL_RESET, OFFSET_RESET, 200, 1'b0);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_plans.size() == 0)
            $display("clock_synth_divider_planner regression: pass");
        else
            $display("clock_synth_divider_planner regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
design/csdp_pkg.sv
design/clock_synth_divider_planner.sv
design/csdp_checker.sv
tb/tb_clock_synth_divider_planner.sv
